[rtl/cv2d_pkg.sv]
package cv2d_pkg;

  localparam int MAX_WIDTH    = 32;
  localparam int MAX_HEIGHT   = 32;
  localparam int MAX_CHANNELS = 4;
  localparam int MAX_FILTERS  = 8;
  localparam int MAX_KERNEL   = 5;

  localparam int FILT_W = 3;
  localparam int CH_W   = 2;
  localparam int POS_W  = 5;
  localparam int DATA_W = 32;
  localparam int PIX_W  = 16;
  localparam int KS_W   = 3;
  localparam int DIM_W  = 6;
  localparam int NC_W   = 3;
  localparam int CFG_W  = 6;
  localparam int ACC_W  = 40;

  localparam int PIX_DEPTH = MAX_CHANNELS * MAX_HEIGHT * MAX_WIDTH;
  localparam int WGT_DEPTH = MAX_FILTERS * MAX_CHANNELS * MAX_KERNEL * MAX_KERNEL;
  localparam int PIX_AW    = $clog2(PIX_DEPTH);
  localparam int WGT_AW    = $clog2(WGT_DEPTH);
  localparam int KK        = MAX_KERNEL * MAX_KERNEL;
  localparam int WPF       = MAX_CHANNELS * KK;

  localparam int S_DATA_W = 48;
  localparam int M_DATA_W = 32;

  typedef enum logic [1:0] {
    CMD_PIXEL,
    CMD_WEIGHT,
    CMD_BIAS,
    CMD_COMPUTE
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_KERNEL,
    CFG_WIDTH,
    CFG_HEIGHT,
    CFG_CHANNELS
  } cfg_idx_e;

  typedef struct packed {
    logic load_bias;
    logic tap_vld;
  } mac_ctrl_t;

  function automatic logic signed [PIX_W-1:0] sat16(input logic signed [DATA_W-1:0] d);
    logic [DATA_W-PIX_W:0] top;
    top = d[DATA_W-1:PIX_W-1];
    if ((&top) || !(|top)) begin
      return d[PIX_W-1:0];
    end
    return d[DATA_W-1] ? {1'b1, {(PIX_W-1){1'b0}}} : {1'b0, {(PIX_W-1){1'b1}}};
  endfunction

  function automatic logic [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] a);
    logic [ACC_W-DATA_W:0] top;
    top = a[ACC_W-1:DATA_W-1];
    if ((&top) || !(|top)) begin
      return a[DATA_W-1:0];
    end
    return a[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
  endfunction

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int hi);
    if (v == '0) begin
      return DIM_W'(1);
    end
    if (int'(v) > hi) begin
      return DIM_W'(hi);
    end
    return v;
  endfunction

  function automatic logic [PIX_AW-1:0] pix_addr(input logic [CH_W-1:0] c,
                                                 input logic [POS_W-1:0] r,
                                                 input logic [POS_W-1:0] x);
    return PIX_AW'((int'(c) * MAX_HEIGHT + int'(r)) * MAX_WIDTH + int'(x));
  endfunction

  function automatic logic [WGT_AW-1:0] wgt_addr(input logic [FILT_W-1:0] f,
                                                 input logic [CH_W-1:0] c,
                                                 input logic [POS_W-1:0] r,
                                                 input logic [POS_W-1:0] x);
    return WGT_AW'(((int'(f) * MAX_CHANNELS + int'(c)) * MAX_KERNEL + int'(r))
                   * MAX_KERNEL + int'(x));
  endfunction

endpackage

[rtl/cv2d_mac.sv]
module cv2d_mac (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  cv2d_pkg::mac_ctrl_t                     ctrl_i,
  input  logic signed [cv2d_pkg::PIX_W-1:0]       pix_i,
  input  logic signed [cv2d_pkg::PIX_W-1:0]       wgt_i,
  input  logic signed [cv2d_pkg::DATA_W-1:0]      bias_i,
  output logic signed [cv2d_pkg::ACC_W-1:0]       acc_o,
  output logic                                    busy_o
);

  logic                                 mul_vld_q;
  logic signed [2*cv2d_pkg::PIX_W-1:0]  prod_q;
  logic signed [cv2d_pkg::ACC_W-1:0]    acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q <= 1'b0;
    end else begin
      mul_vld_q <= ctrl_i.tap_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= pix_i * wgt_i;
    if (ctrl_i.load_bias) begin
      acc_q <= cv2d_pkg::ACC_W'(bias_i);
    end else if (mul_vld_q) begin
      acc_q <= acc_q + cv2d_pkg::ACC_W'(prod_q);
    end
  end

  assign acc_o  = acc_q;
  assign busy_o = mul_vld_q;

endmodule

[rtl/conv2d_valid_multichannel.sv]
// compute request: a window error goes straight to the finish state; otherwise
// one multiply-accumulate per tap through a single shared mac unit
// load requests write their store and leave the sequencer idle
// input is taken only while the sequencer is idle; one output register holds the result
// reset clears control and restores kernel 3, width 32, height 32, channels 1
// pixel, weight and bias stores are not cleared by reset
module conv2d_valid_multichannel (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // filter_index, channel_index, row_index, col_index, data_value, zero pad
  input  logic [cv2d_pkg::S_DATA_W-1:0]   s_axis_tdata,
  // cmd
  input  logic [1:0]                      s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // conv_sum
  output logic [cv2d_pkg::M_DATA_W-1:0]   m_axis_tdata,
  // window_error
  output logic                            m_axis_tuser,
  input  logic                            cfg_we_i,
  input  logic [1:0]                      cfg_idx_i,
  input  logic [cv2d_pkg::CFG_W-1:0]      cfg_data_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_FIN
  } state_e;

  state_e state_q;

  logic [cv2d_pkg::KS_W-1:0]  cfg_kernel_q;
  logic [cv2d_pkg::DIM_W-1:0] cfg_width_q;
  logic [cv2d_pkg::DIM_W-1:0] cfg_height_q;
  logic [cv2d_pkg::NC_W-1:0]  cfg_chan_q;

  logic [cv2d_pkg::KS_W-1:0]   k_q;
  logic [cv2d_pkg::NC_W-1:0]   nc_q;
  logic [cv2d_pkg::POS_W-1:0]  row_q;
  logic [cv2d_pkg::POS_W-1:0]  col_q;
  logic [cv2d_pkg::KS_W-1:0]   kr_q;
  logic [cv2d_pkg::KS_W-1:0]   kc_q;
  logic [cv2d_pkg::CH_W-1:0]   c_q;
  logic [cv2d_pkg::WGT_AW-1:0] wrow_q;
  logic [cv2d_pkg::WGT_AW-1:0] cbase_q;
  logic                        first_q;
  logic                        err_q;
  logic                        rd_vld_q;
  logic                        m_valid_q;
  logic [cv2d_pkg::M_DATA_W-1:0] m_data_q;
  logic                        m_err_q;

  logic [cv2d_pkg::FILT_W-1:0] in_filt;
  logic [cv2d_pkg::CH_W-1:0]   in_chan;
  logic [cv2d_pkg::POS_W-1:0]  in_row;
  logic [cv2d_pkg::POS_W-1:0]  in_col;
  logic signed [cv2d_pkg::DATA_W-1:0] in_data;
  cv2d_pkg::cmd_e              in_cmd;

  logic                        accept;
  logic                        pix_we;
  logic                        wgt_we;
  logic                        bias_we;
  logic                        cmp_start;
  logic                        win_bad;
  logic                        issue;
  logic                        out_free;
  logic                        fin_go;
  logic [cv2d_pkg::DIM_W-1:0]  k_cl;
  logic [cv2d_pkg::DIM_W-1:0]  w_cl;
  logic [cv2d_pkg::DIM_W-1:0]  h_cl;
  logic [cv2d_pkg::DIM_W-1:0]  nc_cl;
  logic [cv2d_pkg::DIM_W:0]    row_end;
  logic [cv2d_pkg::DIM_W:0]    col_end;
  logic [cv2d_pkg::POS_W-1:0]  tap_row;
  logic [cv2d_pkg::POS_W-1:0]  tap_col;
  logic [cv2d_pkg::PIX_AW-1:0] pix_raddr;
  logic [cv2d_pkg::WGT_AW-1:0] wgt_raddr;
  logic [cv2d_pkg::WGT_AW-1:0] filt_base;
  logic                        kc_last;
  logic                        kr_last;
  logic                        c_last;

  logic signed [cv2d_pkg::PIX_W-1:0]  pix_mem [cv2d_pkg::PIX_DEPTH];
  logic signed [cv2d_pkg::PIX_W-1:0]  wgt_mem [cv2d_pkg::WGT_DEPTH];
  logic signed [cv2d_pkg::DATA_W-1:0] bias_mem [cv2d_pkg::MAX_FILTERS];
  logic signed [cv2d_pkg::PIX_W-1:0]  pix_rd_q;
  logic signed [cv2d_pkg::PIX_W-1:0]  wgt_rd_q;
  logic signed [cv2d_pkg::DATA_W-1:0] bias_rd_q;

  cv2d_pkg::mac_ctrl_t                mac_ctrl;
  logic signed [cv2d_pkg::ACC_W-1:0]  acc;
  logic                               mac_busy;

  assign in_filt = s_axis_tdata[2:0];
  assign in_chan = s_axis_tdata[4:3];
  assign in_row  = s_axis_tdata[9:5];
  assign in_col  = s_axis_tdata[14:10];
  assign in_data = s_axis_tdata[46:15];
  assign in_cmd  = cv2d_pkg::cmd_e'(s_axis_tuser);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign k_cl  = cv2d_pkg::clamp_dim(cv2d_pkg::DIM_W'(cfg_kernel_q), cv2d_pkg::MAX_KERNEL);
  assign w_cl  = cv2d_pkg::clamp_dim(cfg_width_q, cv2d_pkg::MAX_WIDTH);
  assign h_cl  = cv2d_pkg::clamp_dim(cfg_height_q, cv2d_pkg::MAX_HEIGHT);
  assign nc_cl = cv2d_pkg::clamp_dim(cv2d_pkg::DIM_W'(cfg_chan_q), cv2d_pkg::MAX_CHANNELS);

  assign row_end = (cv2d_pkg::DIM_W+1)'(in_row) + (cv2d_pkg::DIM_W+1)'(k_cl);
  assign col_end = (cv2d_pkg::DIM_W+1)'(in_col) + (cv2d_pkg::DIM_W+1)'(k_cl);
  assign win_bad = (int'(in_filt) >= cv2d_pkg::MAX_FILTERS)
                || (row_end > (cv2d_pkg::DIM_W+1)'(h_cl))
                || (col_end > (cv2d_pkg::DIM_W+1)'(w_cl));

  assign pix_we    = accept && (in_cmd == cv2d_pkg::CMD_PIXEL)
                  && (int'(in_chan) < cv2d_pkg::MAX_CHANNELS)
                  && (int'(in_row) < cv2d_pkg::MAX_HEIGHT)
                  && (int'(in_col) < cv2d_pkg::MAX_WIDTH);
  assign wgt_we    = accept && (in_cmd == cv2d_pkg::CMD_WEIGHT)
                  && (int'(in_filt) < cv2d_pkg::MAX_FILTERS)
                  && (int'(in_chan) < cv2d_pkg::MAX_CHANNELS)
                  && (int'(in_row) < cv2d_pkg::MAX_KERNEL)
                  && (int'(in_col) < cv2d_pkg::MAX_KERNEL);
  assign bias_we   = accept && (in_cmd == cv2d_pkg::CMD_BIAS)
                  && (int'(in_filt) < cv2d_pkg::MAX_FILTERS);
  assign cmp_start = accept && (in_cmd == cv2d_pkg::CMD_COMPUTE);

  assign filt_base = cv2d_pkg::WGT_AW'(int'(in_filt) * cv2d_pkg::WPF);

  assign issue     = (state_q == ST_ISSUE);
  assign tap_row   = row_q + cv2d_pkg::POS_W'(kr_q);
  assign tap_col   = col_q + cv2d_pkg::POS_W'(kc_q);
  assign pix_raddr = cv2d_pkg::pix_addr(c_q, tap_row, tap_col);
  assign wgt_raddr = wrow_q + cv2d_pkg::WGT_AW'(kc_q);
  assign kc_last   = (kc_q == k_q - 1'b1);
  assign kr_last   = (kr_q == k_q - 1'b1);
  assign c_last    = (cv2d_pkg::NC_W'(c_q) == nc_q - 1'b1);
  assign out_free  = !m_valid_q || m_axis_tready;
  assign fin_go    = (state_q == ST_FIN) && out_free;

  // stores
  always_ff @(posedge clk_i) begin
    if (pix_we) begin
      pix_mem[cv2d_pkg::pix_addr(in_chan, in_row, in_col)] <= cv2d_pkg::sat16(in_data);
    end
    if (issue) begin
      pix_rd_q <= pix_mem[pix_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wgt_we) begin
      wgt_mem[cv2d_pkg::wgt_addr(in_filt, in_chan, in_row, in_col)] <=
        cv2d_pkg::sat16(in_data);
    end
    if (issue) begin
      wgt_rd_q <= wgt_mem[wgt_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (bias_we) begin
      bias_mem[in_filt] <= in_data;
    end
    if (cmp_start) begin
      bias_rd_q <= bias_mem[in_filt];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_kernel_q <= cv2d_pkg::KS_W'(3);
      cfg_width_q  <= cv2d_pkg::DIM_W'(32);
      cfg_height_q <= cv2d_pkg::DIM_W'(32);
      cfg_chan_q   <= cv2d_pkg::NC_W'(1);
    end else if (cfg_we_i) begin
      unique case (cv2d_pkg::cfg_idx_e'(cfg_idx_i))
        cv2d_pkg::CFG_KERNEL:   cfg_kernel_q <= cfg_data_i[cv2d_pkg::KS_W-1:0];
        cv2d_pkg::CFG_WIDTH:    cfg_width_q  <= cfg_data_i[cv2d_pkg::DIM_W-1:0];
        cv2d_pkg::CFG_HEIGHT:   cfg_height_q <= cfg_data_i[cv2d_pkg::DIM_W-1:0];
        cv2d_pkg::CFG_CHANNELS: cfg_chan_q   <= cfg_data_i[cv2d_pkg::NC_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      first_q   <= 1'b0;
      rd_vld_q  <= 1'b0;
      m_valid_q <= 1'b0;
      err_q     <= 1'b0;
      k_q       <= '0;
      nc_q      <= '0;
      row_q     <= '0;
      col_q     <= '0;
      kr_q      <= '0;
      kc_q      <= '0;
      c_q       <= '0;
      wrow_q    <= '0;
      cbase_q   <= '0;
      m_data_q  <= '0;
      m_err_q   <= 1'b0;
    end else begin
      rd_vld_q <= issue;
      if (fin_go) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (cmp_start) begin
            k_q     <= k_cl[cv2d_pkg::KS_W-1:0];
            nc_q    <= nc_cl[cv2d_pkg::NC_W-1:0];
            row_q   <= in_row;
            col_q   <= in_col;
            kr_q    <= '0;
            kc_q    <= '0;
            c_q     <= '0;
            wrow_q  <= filt_base;
            cbase_q <= filt_base;
            err_q   <= win_bad;
            first_q <= 1'b1;
            state_q <= win_bad ? ST_FIN : ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          first_q <= 1'b0;
          if (!kc_last) begin
            kc_q <= kc_q + 1'b1;
          end else begin
            kc_q <= '0;
            if (!kr_last) begin
              kr_q   <= kr_q + 1'b1;
              wrow_q <= wrow_q + cv2d_pkg::WGT_AW'(cv2d_pkg::MAX_KERNEL);
            end else begin
              kr_q    <= '0;
              c_q     <= c_q + 1'b1;
              wrow_q  <= cbase_q + cv2d_pkg::WGT_AW'(cv2d_pkg::KK);
              cbase_q <= cbase_q + cv2d_pkg::WGT_AW'(cv2d_pkg::KK);
              if (c_last) begin
                state_q <= ST_DRAIN;
              end
            end
          end
        end
        ST_DRAIN: begin
          if (!rd_vld_q && !mac_busy) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            m_data_q  <= err_q ? '0 : cv2d_pkg::sat32(acc);
            m_err_q   <= err_q;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign mac_ctrl.load_bias = issue && first_q;
  assign mac_ctrl.tap_vld   = rd_vld_q;

  cv2d_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .pix_i  (pix_rd_q),
    .wgt_i  (wgt_rd_q),
    .bias_i (bias_rd_q),
    .acc_o  (acc),
    .busy_o (mac_busy)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_err_q;

  // a new result only comes out of the finish state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_FIN))
    else $error("result raised outside finish state");

  // an error result carries a zero sum
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("window error with nonzero sum");

  // tap counters stay inside the kernel while issuing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ISSUE) |-> ((kc_q < k_q) && (kr_q < k_q)))
    else $error("tap counter beyond kernel");

  // finish after drain only with an empty mac pipeline
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_FIN) && $past(state_q == ST_DRAIN)) |-> (!rd_vld_q && !mac_busy))
    else $error("mac pipeline not drained");

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import cv2d_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 120;
  localparam int PHASE_ITEMS    = 154;
  localparam longint SUM_MAX    = 64'sd2147483647;
  localparam longint SUM_MIN    = -64'sd2147483648;

  typedef struct {
    logic [DATA_W-1:0] conv_sum;
    logic              window_error;
  } conv_result_t;

  class conv_scoreboard;
    logic [KS_W-1:0]  kernel_reg;
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [NC_W-1:0]  chan_reg;
    shortint          pix_mem[PIX_DEPTH];
    bit               pix_ok[PIX_DEPTH];
    shortint          wgt_mem[WGT_DEPTH];
    bit               wgt_ok[WGT_DEPTH];
    int               bias_mem[MAX_FILTERS];
    bit               bias_ok[MAX_FILTERS];
    conv_result_t     conv_q[$];
    int               errors;
    int               n_results;
    int               n_win_err;
    int               n_sat;

    function new();
      kernel_reg = 3;
      width_reg  = 32;
      height_reg = 32;
      chan_reg   = 1;
    endfunction

    function int clamp_to(int v, int hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function int eff_kernel();
      return clamp_to(int'(kernel_reg), MAX_KERNEL);
    endfunction

    function int eff_width();
      return clamp_to(int'(width_reg), MAX_WIDTH);
    endfunction

    function int eff_height();
      return clamp_to(int'(height_reg), MAX_HEIGHT);
    endfunction

    function int eff_chans();
      return clamp_to(int'(chan_reg), MAX_CHANNELS);
    endfunction

    function int pix_index(int c, int r, int x);
      return (c * MAX_HEIGHT + r) * MAX_WIDTH + x;
    endfunction

    function int wgt_index(int f, int c, int r, int x);
      return ((f * MAX_CHANNELS + c) * MAX_KERNEL + r) * MAX_KERNEL + x;
    endfunction

    function bit window_fits(int r, int x);
      return (r + eff_kernel() <= eff_height()) && (x + eff_kernel() <= eff_width());
    endfunction

    function shortint clip16(logic [DATA_W-1:0] d);
      int v;
      v = d;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return shortint'(v);
    endfunction

    function int pending();
      return conv_q.size();
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CFG_W-1:0] v);
      case (idx)
        CFG_KERNEL:   kernel_reg = v[KS_W-1:0];
        CFG_WIDTH:    width_reg  = v[DIM_W-1:0];
        CFG_HEIGHT:   height_reg = v[DIM_W-1:0];
        CFG_CHANNELS: chan_reg   = v[NC_W-1:0];
        default: ;
      endcase
    endfunction

    function void predict_conv(int f, int r, int x);
      conv_result_t res;
      longint acc;
      int k;
      int nc;
      k  = eff_kernel();
      nc = eff_chans();
      if (!window_fits(r, x)) begin
        res.conv_sum     = '0;
        res.window_error = 1'b1;
      end else begin
        acc = bias_mem[f];
        for (int c = 0; c < nc; c++) begin
          for (int kr = 0; kr < k; kr++) begin
            for (int kc = 0; kc < k; kc++) begin
              acc += longint'(pix_mem[pix_index(c, r + kr, x + kc)]) *
                     longint'(wgt_mem[wgt_index(f, c, kr, kc)]);
            end
          end
        end
        if (acc > SUM_MAX) begin
          acc = SUM_MAX;
          n_sat++;
        end else if (acc < SUM_MIN) begin
          acc = SUM_MIN;
          n_sat++;
        end
        res.conv_sum     = 32'(acc);
        res.window_error = 1'b0;
      end
      conv_q.push_back(res);
    endfunction

    function void note_request(cmd_e cmd, logic [FILT_W-1:0] f, logic [CH_W-1:0] ch,
                               logic [POS_W-1:0] r, logic [POS_W-1:0] x,
                               logic [DATA_W-1:0] d);
      int idx;
      case (cmd)
        CMD_PIXEL: begin
          idx = pix_index(int'(ch), int'(r), int'(x));
          pix_mem[idx] = clip16(d);
          pix_ok[idx]  = 1'b1;
        end
        CMD_WEIGHT: begin
          if (r < MAX_KERNEL && x < MAX_KERNEL) begin
            idx = wgt_index(int'(f), int'(ch), int'(r), int'(x));
            wgt_mem[idx] = clip16(d);
            wgt_ok[idx]  = 1'b1;
          end
        end
        CMD_BIAS: begin
          bias_mem[f] = d;
          bias_ok[f]  = 1'b1;
        end
        default: predict_conv(int'(f), int'(r), int'(x));
      endcase
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("MISMATCH: %s", msg);
    endtask

    task check_result(logic [DATA_W-1:0] sum, logic err);
      conv_result_t want;
      if (conv_q.size() == 0) begin
        report($sformatf("conv result %h (err %b) with no request waiting", sum, err));
      end else begin
        want = conv_q.pop_front();
        n_results++;
        if (want.window_error) n_win_err++;
        if (sum !== want.conv_sum) begin
          report($sformatf("result %0d: conv_sum %h, expected %h",
                           n_results, sum, want.conv_sum));
        end
        if (err !== want.window_error) begin
          report($sformatf("result %0d: window_error %b, expected %b",
                           n_results, err, want.window_error));
        end
      end
    endtask
  endclass

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // filter_index, channel_index, row_index, col_index, data_value, zero pad
  logic [S_DATA_W-1:0] s_axis_tdata  = '0;
  // cmd
  logic [1:0]          s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // conv_sum
  logic [M_DATA_W-1:0] m_axis_tdata;
  // window_error
  logic                m_axis_tuser;
  logic                cfg_we_i      = 1'b0;
  logic [1:0]          cfg_idx_i     = '0;
  logic [CFG_W-1:0]    cfg_data_i    = '0;

  conv_scoreboard sb;
  int burst_left  = 0;
  bit gaps_on     = 1'b1;
  int n_items     = 0;
  int n_ignored   = 0;
  int n_settings  = 0;
  int rx_mode     = 0;
  int rx_count    = 0;
  int quiet_cycles = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  conv2d_valid_multichannel u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // receiver stall pattern
  always @(posedge clk_i) begin
    if (rx_count == 0) begin
      rx_mode  <= $urandom_range(0, 3);
      rx_count <= $urandom_range(20, 200);
    end else begin
      rx_count <= rx_count - 1;
    end
    case (rx_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      2: m_axis_tready <= ($urandom_range(0, 15) == 0);
      default: m_axis_tready <= rx_count[2];
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata, m_axis_tuser);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TIMEOUT: nothing moved for %0d cycles", quiet_cycles);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_req(cmd_e cmd, logic [FILT_W-1:0] f, logic [CH_W-1:0] ch,
                          logic [POS_W-1:0] r, logic [POS_W-1:0] x,
                          logic [DATA_W-1:0] d);
    int gap;
    if (gaps_on && burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      gap = $urandom_range(1, 10);
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(1, 20);
    end
    if (burst_left > 0) burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, d, x, r, ch, f};
    s_axis_tuser  <= cmd;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_request(cmd, f, ch, r, x, d);
    if (cmd == CMD_WEIGHT && (r >= MAX_KERNEL || x >= MAX_KERNEL)) n_ignored++;
    else n_items++;
  endtask

  task automatic drain_results(int extra);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic write_one(cfg_idx_e idx, logic [CFG_W-1:0] v);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    sb.set_reg(idx, v);
  endtask

  task automatic write_regs(int k, int w, int h, int c);
    drain_results(SETTLE_CYCLES);
    write_one(CFG_KERNEL, CFG_W'(k));
    write_one(CFG_WIDTH, CFG_W'(w));
    write_one(CFG_HEIGHT, CFG_W'(h));
    write_one(CFG_CHANNELS, CFG_W'(c));
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  function automatic logic [DATA_W-1:0] rand_value();
    int v;
    logic [15:0] s;
    s = 16'($urandom());
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: begin
        v = $urandom_range(0, 1023);
        return v - 512;
      end
      2: begin
        case ($urandom_range(0, 5))
          0: return 32'h7fff_ffff;
          1: return 32'h8000_0000;
          2: return 32'h0000_7fff;
          3: return 32'hffff_8000;
          4: return 32'h0000_0000;
          default: return 32'hffff_ffff;
        endcase
      end
      3: return {{16{s[15]}}, s};
      default: begin
        v = $urandom_range(0, 2047);
        return v - 1024;
      end
    endcase
  endfunction

  // loads any store entry the window would read before it was written
  task automatic compute_at(int f, int r, int x);
    int k;
    int nc;
    k  = sb.eff_kernel();
    nc = sb.eff_chans();
    if (sb.window_fits(r, x)) begin
      if (!sb.bias_ok[f]) begin
        send_req(CMD_BIAS, FILT_W'(f), 2'($urandom()), 5'($urandom()), 5'($urandom()),
                 rand_value());
      end
      for (int c = 0; c < nc; c++) begin
        for (int kr = 0; kr < k; kr++) begin
          for (int kc = 0; kc < k; kc++) begin
            if (!sb.pix_ok[sb.pix_index(c, r + kr, x + kc)]) begin
              send_req(CMD_PIXEL, 3'($urandom()), CH_W'(c), POS_W'(r + kr), POS_W'(x + kc),
                       rand_value());
            end
            if (!sb.wgt_ok[sb.wgt_index(f, c, kr, kc)]) begin
              send_req(CMD_WEIGHT, FILT_W'(f), CH_W'(c), POS_W'(kr), POS_W'(kc),
                       rand_value());
            end
          end
        end
      end
    end
    send_req(CMD_COMPUTE, FILT_W'(f), 2'($urandom()), POS_W'(r), POS_W'(x), $urandom());
  endtask

  // span is the last valid output position, negative if none fits
  function automatic int pick_pos(int span);
    if (span < 0 || $urandom_range(0, 9) == 0) return $urandom_range(0, 31);
    if ($urandom_range(0, 7) == 0) return ($urandom_range(0, 1) == 1) ? span : 0;
    return $urandom_range(0, (span < 4) ? span : 4);
  endfunction

  task automatic random_load();
    logic [POS_W-1:0] r;
    logic [POS_W-1:0] x;
    case ($urandom_range(0, 2))
      0: send_req(CMD_PIXEL, 3'($urandom()), 2'($urandom()), 5'($urandom()), 5'($urandom()),
                  rand_value());
      1: begin
        if ($urandom_range(0, 4) == 0) begin
          r = 5'($urandom());
          x = 5'($urandom());
        end else begin
          r = 5'($urandom_range(0, MAX_KERNEL - 1));
          x = 5'($urandom_range(0, MAX_KERNEL - 1));
        end
        send_req(CMD_WEIGHT, 3'($urandom()), 2'($urandom()), r, x, rand_value());
      end
      default: send_req(CMD_BIAS, 3'($urandom()), 2'($urandom()), 5'($urandom()),
                        5'($urandom()), rand_value());
    endcase
  endtask

  task automatic run_phase(int item_goal);
    int p;
    int f;
    int hspan;
    int wspan;
    gaps_on = ($urandom_range(0, 3) != 0);
    hspan   = sb.eff_height() - sb.eff_kernel();
    wspan   = sb.eff_width() - sb.eff_kernel();
    while (n_items < item_goal) begin
      p = $urandom_range(0, 99);
      if (p < 2) begin
        drain_results(0);
      end else if (p < 26) begin
        random_load();
      end else begin
        f = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 1);
        compute_at(f, pick_pos(hspan), pick_pos(wspan));
      end
    end
  endtask

  initial begin
    int goal;
    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // 1x1 kernel on a 2x2 map, two channels
    write_regs(1, 2, 2, 2);
    send_req(CMD_PIXEL, 3'd0, 2'd0, 5'd0, 5'd0, 32'h7fff_ffff);
    send_req(CMD_PIXEL, 3'd0, 2'd1, 5'd0, 5'd0, 32'h8000_0000);
    send_req(CMD_WEIGHT, 3'd7, 2'd0, 5'd0, 5'd0, 32'h0000_7fff);
    send_req(CMD_WEIGHT, 3'd7, 2'd1, 5'd0, 5'd0, 32'hffff_8000);
    send_req(CMD_BIAS, 3'd7, 2'd0, 5'd0, 5'd0, 32'h7fff_ffff);
    send_req(CMD_COMPUTE, 3'd7, 2'd0, 5'd0, 5'd0, 32'h0);
    send_req(CMD_WEIGHT, 3'd0, 2'd0, 5'd0, 5'd0, 32'h1234_5678);
    send_req(CMD_WEIGHT, 3'd0, 2'd1, 5'd0, 5'd0, 32'h0000_7fff);
    send_req(CMD_BIAS, 3'd0, 2'd3, 5'd31, 5'd31, 32'h8000_0000);
    send_req(CMD_COMPUTE, 3'd0, 2'd3, 5'd0, 5'd0, 32'hffff_ffff);
    send_req(CMD_WEIGHT, 3'd3, 2'd3, 5'd31, 5'd31, 32'hffff_ffff);
    send_req(CMD_WEIGHT, 3'd3, 2'd2, 5'd5, 5'd0, 32'h0000_0100);
    send_req(CMD_PIXEL, 3'd7, 2'd3, 5'd31, 5'd31, 32'h0000_0100);
    send_req(CMD_COMPUTE, 3'd7, 2'd0, 5'd2, 5'd0, 32'h0);
    send_req(CMD_COMPUTE, 3'd7, 2'd0, 5'd31, 5'd31, 32'h0);
    compute_at(7, 1, 1);
    compute_at(0, 0, 1);
    send_req(CMD_BIAS, 3'd7, 2'd0, 5'd0, 5'd0, 32'h0);
    compute_at(7, 0, 0);

    goal = n_items;
    write_regs(3, 32, 32, 1);
    goal += PHASE_ITEMS;
    run_phase(goal);
    write_regs(1, 1, 1, 1);
    goal += PHASE_ITEMS;
    run_phase(goal);
    write_regs(2, 6, 9, 2);
    goal += PHASE_ITEMS;
    run_phase(goal);
    // zero in every register reads as one
    write_regs(0, 0, 0, 0);
    goal += PHASE_ITEMS;
    run_phase(goal);
    write_regs(5, 8, 8, 4);
    goal += PHASE_ITEMS;
    run_phase(goal);
    // all ones, clamped to the maximum sizes
    write_regs(7, 63, 63, 7);
    goal += PHASE_ITEMS;
    run_phase(goal);
    write_regs(4, 32, 5, 3);
    goal += PHASE_ITEMS;
    run_phase(goal);
    write_regs(5, 5, 5, 4);
    goal += PHASE_ITEMS;
    run_phase(goal);

    drain_results(SETTLE_CYCLES);
    $display("stimulus: %0d load/compute requests plus %0d ignored loads, %0d register settings",
             n_items, n_ignored, n_settings);
    $display("checked %0d conv results, %0d window errors, %0d saturated sums",
             sb.n_results, sb.n_win_err, sb.n_sat);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
